// ----- rtl/core/lcd_character_terminal_defines.svh -----
// ----------------------------------------------------------------------------
// lcd_character_terminal_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LCD_CHARACTER_TERMINAL_DEFINES_SVH
`define LCD_CHARACTER_TERMINAL_DEFINES_SVH

// same-cycle implication
`define LCDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdt_pkg
// types, codes and the row start table of the character terminal
// ----------------------------------------------------------------------------
package lcdt_pkg;

  localparam int unsigned MaxColumnsDefault = 40;

  typedef logic [7:0] char_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [5:0] cfg_data_t;
  typedef logic [5:0] col_t;
  typedef logic [1:0] row_t;

  // result kinds
  localparam kind_t KIND_INSTR     = 2'd0;
  localparam kind_t KIND_DATA      = 2'd1;
  localparam kind_t KIND_BACKLIGHT = 2'd2;

  // register indexes
  localparam cfg_idx_t CFG_COLUMNS   = 2'd0;
  localparam cfg_idx_t CFG_ROWS      = 2'd1;
  localparam cfg_idx_t CFG_TAB_WIDTH = 2'd2;
  localparam cfg_idx_t CFG_TABLE_SEL = 2'd3;

  // register reset values
  localparam logic [5:0] COLUMNS_RESET   = 6'd16;
  localparam logic [2:0] ROWS_RESET      = 3'd2;
  localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
  localparam logic       TABLE_SEL_RESET = 1'b0;

  // control codes
  localparam char_t CHAR_BEL = 8'h07;
  localparam char_t CHAR_BS  = 8'h08;
  localparam char_t CHAR_TAB = 8'h09;
  localparam char_t CHAR_LF  = 8'h0A;
  localparam char_t CHAR_FF  = 8'h0C;
  localparam char_t CHAR_CR  = 8'h0D;

  // controller bytes
  localparam logic [7:0] INSTR_CLEAR   = 8'h01;
  localparam logic [7:0] INSTR_SET_DDR = 8'h80;
  localparam logic [7:0] DATA_SPACE    = 8'h20;
  localparam logic [7:0] LIGHT_OFF     = 8'h00;
  localparam logic [7:0] LIGHT_ON      = 8'h01;

  typedef struct packed {
    logic [7:0] cmd;
    col_t       col;
    row_t       row;
  } cursor_cmd_t;

  function automatic logic [6:0] row_start(input logic sel, input row_t row);
    logic [6:0] s;
    unique case (row)
      2'd0:    s = 7'h00;
      2'd1:    s = 7'h40;
      2'd2:    s = sel ? 7'h10 : 7'h14;
      default: s = sel ? 7'h50 : 7'h54;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/lcdt_if.sv -----
// ----------------------------------------------------------------------------
// lcdt_if
// valid/ready channels of the character terminal
// ----------------------------------------------------------------------------
interface lcdt_char_if;
  logic                 valid;
  logic                 ready;
  lcdt_pkg::char_t      char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface lcdt_res_if;
  logic                 valid;
  logic                 ready;
  lcdt_pkg::kind_t      kind;
  logic [7:0]           value;
  logic                 last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface lcdt_cfg_if;
  logic                 valid;
  logic                 ready;
  lcdt_pkg::cfg_idx_t   index;
  lcdt_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/lcdt_cursor_cmd.sv -----
// ----------------------------------------------------------------------------
// lcdt_cursor_cmd
// wraps an out-of-range cursor position to zero and forms the set-address instruction
// ----------------------------------------------------------------------------
module lcdt_cursor_cmd (
  input  logic [6:0]            x_i,
  input  logic [2:0]            y_i,
  input  logic [5:0]            width_i,
  input  logic [2:0]            height_i,
  input  logic                  table_sel_i,
  output lcdt_pkg::cursor_cmd_t cmd_o
);

  lcdt_pkg::col_t xc;
  lcdt_pkg::row_t yc;
  logic [6:0]     addr;

  always_comb begin
    xc   = (x_i >= {1'b0, width_i}) ? '0 : x_i[5:0];
    yc   = (y_i >= height_i) ? '0 : y_i[1:0];
    addr = {1'b0, xc} + lcdt_pkg::row_start(table_sel_i, yc);
    cmd_o.cmd = lcdt_pkg::INSTR_SET_DDR | {1'b0, addr};
    cmd_o.col = xc;
    cmd_o.row = yc;
  end

endmodule

// ----- rtl/core/lcd_character_terminal.sv -----
// ----------------------------------------------------------------------------
// lcd_character_terminal
// turns character codes into controller instruction, data and backlight bytes
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  char_i   in   valid/ready    char_code
//  res_o    out  valid/ready    kind, value, last
//  cfg_i    in   valid/ready    index, data (always ready)
//
//  a character is taken in idle, then one result byte per cycle while res_o
//  is free; a printable code that wraps first feeds a line of spaces
//  tab first steps an accumulator by tab_width until it passes the column
//  char_i ready only between characters; res_o stalls hold the sequencer
//  reset clears cursor and registers to their reset values, no clearing pass
// ----------------------------------------------------------------------------
module lcd_character_terminal #(
  parameter int unsigned MAX_COLUMNS = lcdt_pkg::MaxColumnsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lcdt_char_if.sink  char_i,
  lcdt_res_if.source res_o,
  lcdt_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_TAB, S_SETCUR, S_NL1, S_NLSP, S_NL2, S_DATA, S_CLEAR, S_BELL0, S_BELL1
  } state_e;

  state_e          state_q;
  logic [5:0]      columns_q;
  logic [2:0]      rows_q;
  logic [4:0]      tab_q;
  logic            sel_q;
  lcdt_pkg::col_t  col_q;
  lcdt_pkg::row_t  row_q;
  lcdt_pkg::char_t char_q;
  logic [6:0]      x_q;
  logic [2:0]      y_q;
  logic [6:0]      acc_q;
  logic [5:0]      cnt_q;
  logic            pend_q;
  logic            res_valid_q;
  lcdt_pkg::kind_t res_kind_q;
  logic [7:0]      res_value_q;
  logic            res_last_q;

  logic [5:0]            width;
  logic [2:0]            height;
  logic [4:0]            tab_eff;
  logic                  slot_free;
  logic [6:0]            cur_x;
  logic [2:0]            cur_y;
  lcdt_pkg::cursor_cmd_t cur;

  always_comb begin
    if (columns_q == '0) begin
      width = 6'd1;
    end else if ({26'd0, columns_q} > MAX_COLUMNS) begin
      width = 6'(MAX_COLUMNS);
    end else begin
      width = columns_q;
    end
    if (rows_q == '0) begin
      height = 3'd1;
    end else if (rows_q > 3'd4) begin
      height = 3'd4;
    end else begin
      height = rows_q;
    end
    tab_eff = (tab_q == '0) ? 5'd1 : tab_q;
  end

  always_comb begin
    unique case (state_q)
      S_NL1: begin
        cur_x = '0;
        cur_y = {1'b0, row_q} + 3'd1;
      end
      S_NL2: begin
        cur_x = {1'b0, col_q};
        cur_y = {1'b0, row_q};
      end
      default: begin
        cur_x = x_q;
        cur_y = y_q;
      end
    endcase
  end

  lcdt_cursor_cmd u_cursor_cmd (
    .x_i         (cur_x),
    .y_i         (cur_y),
    .width_i     (width),
    .height_i    (height),
    .table_sel_i (sel_q),
    .cmd_o       (cur)
  );

  assign slot_free     = !res_valid_q || res_o.ready;
  assign char_i.ready  = (state_q == S_IDLE);
  assign res_o.valid   = res_valid_q;
  assign res_o.kind    = res_kind_q;
  assign res_o.value   = res_value_q;
  assign res_o.last    = res_last_q;
  assign cfg_i.ready   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= lcdt_pkg::COLUMNS_RESET;
      rows_q    <= lcdt_pkg::ROWS_RESET;
      tab_q     <= lcdt_pkg::TAB_WIDTH_RESET;
      sel_q     <= lcdt_pkg::TABLE_SEL_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lcdt_pkg::CFG_COLUMNS:   columns_q <= cfg_i.data;
        lcdt_pkg::CFG_ROWS:      rows_q    <= cfg_i.data[2:0];
        lcdt_pkg::CFG_TAB_WIDTH: tab_q     <= cfg_i.data[4:0];
        lcdt_pkg::CFG_TABLE_SEL: sel_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      char_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_kind_q  <= lcdt_pkg::KIND_INSTR;
      res_value_q <= '0;
      res_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
          end
          if (char_i.valid) begin
            char_q <= char_i.char_code;
            pend_q <= 1'b0;
            acc_q  <= '0;
            unique case (char_i.char_code)
              lcdt_pkg::CHAR_CR: begin
                x_q     <= '0;
                y_q     <= {1'b0, row_q};
                state_q <= S_SETCUR;
              end
              lcdt_pkg::CHAR_LF: state_q <= S_NL1;
              lcdt_pkg::CHAR_TAB: state_q <= S_TAB;
              lcdt_pkg::CHAR_FF: state_q <= S_CLEAR;
              lcdt_pkg::CHAR_BS: begin
                x_q     <= (col_q == '0) ? '1 : {1'b0, col_q - 6'd1};
                y_q     <= {1'b0, row_q};
                state_q <= S_SETCUR;
              end
              lcdt_pkg::CHAR_BEL: state_q <= S_BELL0;
              default: begin
                if (col_q >= width) begin
                  pend_q  <= 1'b1;
                  state_q <= S_NL1;
                end else begin
                  state_q <= S_DATA;
                end
              end
            endcase
          end
        end
        S_TAB: begin
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
          end
          if (acc_q <= {1'b0, col_q}) begin
            acc_q <= acc_q + {2'b00, tab_eff};
          end else begin
            x_q     <= acc_q;
            y_q     <= {1'b0, row_q} + {2'b00, (acc_q >= {1'b0, width})};
            state_q <= S_SETCUR;
          end
        end
        S_SETCUR: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_INSTR;
            res_value_q <= cur.cmd;
            res_last_q  <= 1'b1;
            col_q       <= cur.col;
            row_q       <= cur.row;
            state_q     <= S_IDLE;
          end
        end
        S_NL1: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_INSTR;
            res_value_q <= cur.cmd;
            res_last_q  <= 1'b0;
            col_q       <= cur.col;
            row_q       <= cur.row;
            cnt_q       <= '0;
            state_q     <= S_NLSP;
          end
        end
        S_NLSP: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_DATA;
            res_value_q <= lcdt_pkg::DATA_SPACE;
            res_last_q  <= 1'b0;
            cnt_q       <= cnt_q + 6'd1;
            if (cnt_q == width - 6'd1) begin
              state_q <= S_NL2;
            end
          end
        end
        S_NL2: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_INSTR;
            res_value_q <= cur.cmd;
            res_last_q  <= !pend_q;
            col_q       <= cur.col;
            row_q       <= cur.row;
            state_q     <= pend_q ? S_DATA : S_IDLE;
          end
        end
        S_DATA: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_DATA;
            res_value_q <= char_q;
            res_last_q  <= 1'b1;
            col_q       <= col_q + 6'd1;
            state_q     <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_INSTR;
            res_value_q <= lcdt_pkg::INSTR_CLEAR;
            res_last_q  <= 1'b1;
            col_q       <= '0;
            row_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_BELL0: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_BACKLIGHT;
            res_value_q <= lcdt_pkg::LIGHT_OFF;
            res_last_q  <= 1'b0;
            state_q     <= S_BELL1;
          end
        end
        S_BELL1: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_kind_q  <= lcdt_pkg::KIND_BACKLIGHT;
            res_value_q <= lcdt_pkg::LIGHT_ON;
            res_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/lcdt_checker.sv -----
// ----------------------------------------------------------------------------
// lcdt_checker
// port-level checks of the character terminal, bound to the top level
// ----------------------------------------------------------------------------
`include "lcd_character_terminal_defines.svh"

module lcdt_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input lcdt_pkg::kind_t out_kind_i,
  input logic [7:0]      out_value_i,
  input logic            out_last_i
);

  // one character at a time
  `LCDT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "character taken while busy")

  // a pending result that is not the final one keeps the input closed
  `LCDT_ASSERT_IMP(a_no_take_mid_seq, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "input open before final result")

  // backlight level is a single bit
  `LCDT_ASSERT_IMP(a_light_level, clk_i, rst_ni, out_valid_i && (out_kind_i == lcdt_pkg::KIND_BACKLIGHT), out_value_i[7:1] == 7'd0, "bad backlight level")

  // stalled result holds
  `LCDT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i) && $stable(out_kind_i) && $stable(out_last_i), "stalled result changed")

endmodule

bind lcd_character_terminal lcdt_checker u_lcdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (char_i.valid),
  .in_ready_i  (char_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.kind),
  .out_value_i (res_o.value),
  .out_last_i  (res_o.last)
);

// ----- tb/lcdt_output_check.sv -----
// ----------------------------------------------------------------------------
// lcdt_output_check
// watches the terminal's channels, predicts its controller bytes and compares
// ----------------------------------------------------------------------------
// Tracks the register writes and the cursor in its own copy of the terminal
// state. Each accepted character adds its expected bytes to a queue. Each
// accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module lcdt_output_check #(
  parameter int unsigned MAX_COLUMNS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdt_char_if        chr,
  lcdt_res_if         res,
  lcdt_cfg_if         cfg,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcdt_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } lcd_byte_t;

  lcd_byte_t   expected_bytes[$];
  lcd_byte_t   want;
  lcd_byte_t   got;
  logic [5:0]  columns_q;
  logic [2:0]  rows_q;
  logic [4:0]  tab_q;
  logic        table_q;
  col_t        col_q;
  row_t        row_q;
  int unsigned mismatches;

  function automatic int unsigned line_width();
    if (columns_q == 0) return 1;
    if (columns_q > MAX_COLUMNS) return MAX_COLUMNS;
    return columns_q;
  endfunction

  function automatic int unsigned line_count();
    if (rows_q == 0) return 1;
    if (rows_q > 4) return 4;
    return rows_q;
  endfunction

  function automatic int unsigned row_base(int unsigned y);
    case (y)
      0:       return 'h00;
      1:       return 'h40;
      2:       return table_q ? 'h10 : 'h14;
      default: return table_q ? 'h50 : 'h54;
    endcase
  endfunction

  task automatic put_byte(kind_t k, logic [7:0] v);
    expected_bytes.push_back('{kind: k, value: v, last: 1'b0});
  endtask

  task automatic move_cursor(int unsigned x, int unsigned y);
    if (x >= line_width()) x = 0;
    if (y >= line_count()) y = 0;
    put_byte(KIND_INSTR, INSTR_SET_DDR | 8'((x + row_base(y)) & 'h7f));
    col_q = col_t'(x);
    row_q = row_t'(y);
  endtask

  task automatic feed_line();
    int unsigned w;
    w = line_width();
    move_cursor(0, int'(row_q) + 1);
    repeat (w) put_byte(KIND_DATA, DATA_SPACE);
    move_cursor(col_q, row_q);
  endtask

  task automatic render_char(char_t c);
    int unsigned t;
    int unsigned x;
    case (c)
      CHAR_CR:  move_cursor(0, row_q);
      CHAR_LF:  feed_line();
      CHAR_TAB: begin
        t = (tab_q == 0) ? 1 : tab_q;
        x = col_q + t - (col_q % t);
        move_cursor(x, int'(row_q) + ((x >= line_width()) ? 1 : 0));
      end
      CHAR_FF: begin
        put_byte(KIND_INSTR, INSTR_CLEAR);
        col_q = '0;
        row_q = '0;
      end
      // stepping back from column 0 lands out of range and so at column 0
      CHAR_BS:  move_cursor((col_q == 0) ? 255 : int'(col_q) - 1, row_q);
      CHAR_BEL: begin
        put_byte(KIND_BACKLIGHT, LIGHT_OFF);
        put_byte(KIND_BACKLIGHT, LIGHT_ON);
      end
      default: begin
        if (col_q >= line_width()) feed_line();
        col_q = col_q + 1'b1;
        put_byte(KIND_DATA, c);
      end
    endcase
    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      columns_q  = COLUMNS_RESET;
      rows_q     = ROWS_RESET;
      tab_q      = TAB_WIDTH_RESET;
      table_q    = TABLE_SEL_RESET;
      col_q      = '0;
      row_q      = '0;
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_COLUMNS:   columns_q = cfg.data;
          CFG_ROWS:      rows_q    = cfg.data[2:0];
          CFG_TAB_WIDTH: tab_q     = cfg.data[4:0];
          CFG_TABLE_SEL: table_q   = cfg.data[0];
          default: ;
        endcase
      end
      if (chr.valid && chr.ready) render_char(chr.char_code);
      if (res.valid && res.ready) begin
        got = '{kind: res.kind, value: res.value, last: res.last};
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("check: unexpected transaction kind %0d value %02h last %0b",
                     got.kind, got.value, got.last);
        end else begin
          want = expected_bytes.pop_front();
          if (got.kind !== want.kind || got.value !== want.value
              || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("check: expected kind %0d value %02h last %0b, got kind %0d value %02h last %0b",
                       want.kind, want.value, want.last, got.kind, got.value, got.last);
          end
        end
      end
    end
    errors_o  = mismatches;
    pending_o = expected_bytes.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the character terminal
// ----------------------------------------------------------------------------
// A short directed run at the reset settings and at narrow settings. Then
// several phases of random text, each under new register settings. Both
// channels idle at random. One phase runs without idling, and in one the
// result side holds off for a long stretch. Checking is done in
// lcdt_output_check.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdt_pkg::*;

  localparam int unsigned MaxCols     = 40;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned Phases      = 8;
  localparam int unsigned PhaseItems  = 24;
  localparam int unsigned HoldCycles  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;

  lcdt_char_if chr ();
  lcdt_res_if  res ();
  lcdt_cfg_if  cfg ();

  lcd_character_terminal #(
    .MAX_COLUMNS(MaxCols)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(chr),
    .res_o (res),
    .cfg_i (cfg)
  );

  lcdt_output_check #(
    .MAX_COLUMNS(MaxCols)
  ) u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .chr      (chr),
    .res      (res),
    .cfg      (cfg),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        res.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      res.ready = calm || ($urandom_range(99) >= 38);
    end
  end

  task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic set_all(cfg_data_t c, cfg_data_t r, cfg_data_t t, cfg_data_t s);
    write_reg(CFG_COLUMNS, c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_TAB_WIDTH, t);
    write_reg(CFG_TABLE_SEL, s);
  endtask

  task automatic send_char(char_t c);
    if (!calm && $urandom_range(99) < 38) begin
      chr.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    chr.valid     = 1'b1;
    chr.char_code = c;
    do @(posedge clk_i); while (!chr.ready);
    @(negedge clk_i);
  endtask

  task automatic settle(int unsigned extra);
    chr.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  function automatic char_t pick_char();
    case ($urandom_range(19))
      0, 1:    return CHAR_LF;
      2, 3:    return CHAR_CR;
      4, 5:    return CHAR_TAB;
      6, 7:    return CHAR_BS;
      8:       return CHAR_BEL;
      9:       return CHAR_FF;
      default: return char_t'($urandom_range(255));
    endcase
  endfunction

  function automatic cfg_data_t pick_width();
    case ($urandom_range(3))
      0, 1:    return cfg_data_t'($urandom_range(1, 8));
      2:       return cfg_data_t'($urandom_range(9, 20));
      default: return cfg_data_t'($urandom_range(63));
    endcase
  endfunction

  initial begin
    char_t       opening [14] = '{CHAR_FF, CHAR_BS, 8'h00, 8'hff, 8'h41, CHAR_BEL, CHAR_TAB,
                                  CHAR_BS, CHAR_CR, CHAR_LF, CHAR_TAB, CHAR_TAB, CHAR_TAB,
                                  CHAR_TAB};
    char_t       narrow [8]   = '{8'h7f, 8'h80, 8'h55, 8'haa, CHAR_TAB, CHAR_TAB, CHAR_LF,
                                  CHAR_LF};
    int unsigned p;
    int unsigned i;

    chr.valid     = 1'b0;
    chr.char_code = '0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_COLUMNS;
    cfg.data      = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings
    foreach (opening[k]) send_char(opening[k]);
    settle(8);
    // two columns, four rows, zero tab, second table
    set_all(6'd2, 6'd4, 6'd0, 6'd1);
    foreach (narrow[k]) send_char(narrow[k]);

    for (p = 0; p < Phases; p++) begin
      settle(8);
      case (p)
        0:       set_all(6'd63, 6'd0, 6'd31, 6'd0);
        1:       set_all(6'd40, 6'd7, 6'd16, 6'd1);
        2:       set_all(6'd1, 6'd1, 6'd1, 6'd0);
        default: set_all(pick_width(), cfg_data_t'($urandom_range(63)),
                         cfg_data_t'($urandom_range(63)), cfg_data_t'($urandom_range(63)));
      endcase
      calm = (p == 3);
      if (p == 4) hold_req = 1'b1;
      for (i = 0; i < PhaseItems; i++) send_char(pick_char());
    end

    settle(50);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lcdt_pkg.sv
rtl/core/lcdt_if.sv
rtl/core/lcdt_cursor_cmd.sv
rtl/core/lcd_character_terminal.sv
rtl/core/lcdt_checker.sv
tb/lcdt_output_check.sv
tb/tb.sv
